/* hw/rtl/psr_pkg.sv */
// ----------------------------------------------------------------------------
// psr_pkg
// Types, constants and helper functions for the PSI section reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

  localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [11:0] MAX_SECTION_LEN = 12'd4093;
  localparam logic [11:0] MIN_EXT_LEN     = 12'd9;
  localparam logic [11:0] MIN_STD_LEN     = 12'd4;
  localparam logic [7:0]  FIXED_BITS_MASK = 8'h30;
  localparam logic [7:0]  EXT_RSV_MASK    = 8'hC0;
  localparam logic [12:0] HDR_STD_BYTES   = 13'd3;
  localparam logic [12:0] HDR_EXT_BYTES   = 13'd8;
  localparam logic [12:0] SECTION_OVERHEAD = 13'd3;

  typedef logic [7:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_start;
    logic       unit_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  section_byte;
    logic        in_section;
    logic [11:0] byte_offset;
    logic        section_done;
    logic        crc_good;
    logic [31:0] crc_error_count;
    logic [7:0]  table_id;
    logic [15:0] table_id_extension;
    logic [4:0]  version_number;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section_number;
  } out_item_t;

  // msb-first crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [11:0] section_len(input hdr_bytes_t h);
    return {h[1][3:0], h[2]};
  endfunction

  function automatic logic header_ok(input hdr_bytes_t h, input logic ext);
    logic [11:0] len;
    logic        ok;
    len = section_len(h);
    ok  = 1'b1;
    if ((h[1] & FIXED_BITS_MASK) != FIXED_BITS_MASK) ok = 1'b0;
    if (len > MAX_SECTION_LEN) ok = 1'b0;
    if (h[1][7]) begin
      if (!ext) ok = 1'b0;
      if ((h[5] & EXT_RSV_MASK) != EXT_RSV_MASK) ok = 1'b0;
      if (h[6] > h[7]) ok = 1'b0;
      if (len < MIN_EXT_LEN) ok = 1'b0;
    end else begin
      if (ext) ok = 1'b0;
      if (len < MIN_STD_LEN) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/psr_stream_if.sv */
// ----------------------------------------------------------------------------
// psr_stream_if
// Valid/ready channels for payload bytes and section results.
// ----------------------------------------------------------------------------
`default_nettype none

interface psr_in_if import psr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psr_out_if import psr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/psi_section_reassembler_unit.sv */
// ----------------------------------------------------------------------------
// psi_section_reassembler_unit
// Rebuilds PSI sections from transport-stream payload bytes with crc check.
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while the result side does not stall and
// returns one result per byte, through an input register, then combinational
// header check and byte-wide crc-32 update, then the result register. The
// byte rate is set by that parser step; the input side keeps accepting
// while a result waits, stopping only when both registers are full.
// Writing a changed extended_mode value restarts the parser and clears the
// crc error count.
`default_nettype none

module psi_section_reassembler_unit import psr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  psr_in_if.sink    ts_in,
  psr_out_if.source sec_out
);

  logic      item_valid;
  in_item_t  item;
  out_item_t result;
  logic      step;

  assign step = item_valid && (!sec_out.valid || sec_out.ready);

  psr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .ts_in      (ts_in),
    .advance    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  psr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  psr_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .advance (step),
    .result  (result),
    .sec_out (sec_out)
  );

  a_done_stored: assert property (@(posedge clk) disable iff (rst)
    sec_out.valid && sec_out.data.section_done |-> sec_out.data.in_section)
    else $error("section end on a byte that was not stored");

  a_good_with_done: assert property (@(posedge clk) disable iff (rst)
    sec_out.valid && sec_out.data.crc_good |-> sec_out.data.section_done)
    else $error("crc status outside section end");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    sec_out.valid && !sec_out.data.in_section |-> sec_out.data.byte_offset == '0)
    else $error("offset on a byte outside a section");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> sec_out.valid && sec_out.data.section_byte == $past(item.payload_byte))
    else $error("result register missed a parser step");

endmodule

`default_nettype wire

/* hw/rtl/psr_in_reg.sv */
// ----------------------------------------------------------------------------
// psr_in_reg
// Input register for payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_in_reg import psr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  psr_in_if.sink    ts_in,
  input  wire logic advance,
  output logic      item_valid,
  output in_item_t  item
);

  assign ts_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (ts_in.ready) begin
      item_valid <= ts_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ts_in.valid && ts_in.ready) begin
      item <= ts_in.data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psr_core.sv */
// ----------------------------------------------------------------------------
// psr_core
// Section parser state, header check and crc update for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_core import psr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      step,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic        extended_mode;
  logic        storing_payload;
  hdr_bytes_t  header_store;
  logic [12:0] stored_count;
  logic [12:0] target_size;
  logic [31:0] running_crc;
  logic [31:0] error_counter;
  logic [7:0]  packet_position;
  logic [7:0]  new_section_position;
  logic        pass_finished;
  logic        packet_has_unit_start;

  logic        storing_payload_next;
  hdr_bytes_t  header_store_next;
  logic [12:0] stored_count_next;
  logic [12:0] target_size_next;
  logic [31:0] running_crc_next;
  logic [31:0] error_counter_next;
  logic [7:0]  packet_position_next;
  logic [7:0]  new_section_position_next;
  logic        pass_finished_next;
  logic        packet_has_unit_start_next;

  logic        pointer;
  logic        restart;
  logic        process;
  logic        storing_eff;
  logic [12:0] count_eff;
  logic [12:0] target_eff;
  logic [31:0] crc_eff;
  logic [31:0] crc_upd;
  logic [12:0] count_inc;
  logic [12:0] hdr_size;
  logic        done;
  logic        good;
  logic        show_hdr;
  logic        show_ext;

  always_comb begin
    packet_position_next       = packet_position;
    new_section_position_next  = new_section_position;
    packet_has_unit_start_next = packet_has_unit_start;
    pass_finished_next         = pass_finished;
    pointer                    = 1'b0;
    restart                    = 1'b0;

    if (item.packet_start) begin
      packet_position_next       = '0;
      pass_finished_next         = 1'b0;
      packet_has_unit_start_next = item.unit_start;
      if (item.unit_start) begin
        new_section_position_next = (item.payload_byte == 8'hFF) ? 8'hFF
                                    : item.payload_byte + 8'd1;
        pointer = 1'b1;
      end
    end else begin
      packet_position_next = (packet_position == 8'hFF) ? 8'hFF : packet_position + 8'd1;
      if (packet_has_unit_start && packet_position_next == new_section_position) begin
        packet_has_unit_start_next = 1'b0;
        restart                    = 1'b1;
        pass_finished_next         = 1'b0;
      end
    end

    storing_eff = restart ? 1'b0 : storing_payload;
    count_eff   = restart ? '0 : stored_count;
    target_eff  = restart ? '0 : target_size;
    crc_eff     = restart ? CRC_INIT : running_crc;

    process   = !pointer && !pass_finished_next;
    crc_upd   = crc_byte(crc_eff, item.payload_byte);
    count_inc = count_eff + 13'd1;
    hdr_size  = extended_mode ? HDR_EXT_BYTES : HDR_STD_BYTES;

    header_store_next = header_store;
    if (process && !storing_eff) begin
      header_store_next[count_eff[2:0]] = item.payload_byte;
    end

    storing_payload_next = storing_eff;
    stored_count_next    = count_eff;
    target_size_next     = target_eff;
    running_crc_next     = crc_eff;
    error_counter_next   = error_counter;
    done                 = 1'b0;
    good                 = 1'b0;

    if (process) begin
      running_crc_next  = crc_upd;
      stored_count_next = count_inc;
      if (!storing_eff) begin
        if (count_inc >= hdr_size) begin
          if (header_ok(header_store_next, extended_mode)) begin
            storing_payload_next = 1'b1;
            target_size_next     = {1'b0, section_len(header_store_next)} + SECTION_OVERHEAD;
          end else begin
            storing_payload_next = 1'b0;
            stored_count_next    = '0;
            target_size_next     = '0;
            running_crc_next     = CRC_INIT;
            pass_finished_next   = 1'b1;
          end
        end
      end else if (count_inc >= target_eff) begin
        done = 1'b1;
        good = (crc_upd == '0);
        if (!good && error_counter != '1) begin
          error_counter_next = error_counter + 32'd1;
        end
        pass_finished_next = 1'b1;
      end
    end

    show_hdr = storing_payload_next;
    show_ext = show_hdr && extended_mode;

    result.section_byte        = item.payload_byte;
    result.in_section          = process;
    result.byte_offset         = process ? count_eff[11:0] : '0;
    result.section_done        = done;
    result.crc_good            = good;
    result.crc_error_count     = error_counter_next;
    result.table_id            = show_hdr ? header_store_next[0] : '0;
    result.table_id_extension  = show_ext ? {header_store_next[3], header_store_next[4]} : '0;
    result.version_number      = show_ext ? header_store_next[5][5:1] : '0;
    result.current_next        = show_ext ? header_store_next[5][0] : 1'b0;
    result.section_number      = show_ext ? header_store_next[6] : '0;
    result.last_section_number = show_ext ? header_store_next[7] : '0;

    if (done) begin
      storing_payload_next = 1'b0;
      stored_count_next    = '0;
      target_size_next     = '0;
      running_crc_next     = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_mode         <= 1'b1;
      storing_payload       <= 1'b0;
      stored_count          <= '0;
      target_size           <= '0;
      running_crc           <= CRC_INIT;
      error_counter         <= '0;
      packet_position       <= '0;
      new_section_position  <= '0;
      pass_finished         <= 1'b0;
      packet_has_unit_start <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_wdata != extended_mode) begin
        extended_mode   <= cfg_wdata;
        storing_payload <= 1'b0;
        stored_count    <= '0;
        target_size     <= '0;
        running_crc     <= CRC_INIT;
        error_counter   <= '0;
        pass_finished   <= 1'b0;
      end
    end else if (step) begin
      storing_payload       <= storing_payload_next;
      stored_count          <= stored_count_next;
      target_size           <= target_size_next;
      running_crc           <= running_crc_next;
      error_counter         <= error_counter_next;
      packet_position       <= packet_position_next;
      new_section_position  <= new_section_position_next;
      pass_finished         <= pass_finished_next;
      packet_has_unit_start <= packet_has_unit_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !cfg_we) begin
      header_store <= header_store_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psr_out_reg.sv */
// ----------------------------------------------------------------------------
// psr_out_reg
// Result register for section bytes and status.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_out_reg import psr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  wire out_item_t result,
  psr_out_if.source      sec_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_out.valid <= 1'b0;
    end else if (advance) begin
      sec_out.valid <= 1'b1;
    end else if (sec_out.ready) begin
      sec_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sec_out.data <= result;
    end
  end

endmodule

`default_nettype wire

/* test/psi_crc_pkg.sv */
// ----------------------------------------------------------------------------
// psi_crc_pkg
// Bitwise msb-first crc-32 step shared by the section generator and checker.
// ----------------------------------------------------------------------------
package psi_crc_pkg;

  import psr_pkg::CRC_POLY;

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[31] ^ data[k];
      r  = r << 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* test/psi_section_checker.sv */
// ----------------------------------------------------------------------------
// psi_section_checker
// Watches both channels of the section reassembler and the mode register
// write port. Every input transfer runs through a cycle-free parser model
// that queues the result it should cause; every output transfer is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module psi_section_checker import psr_pkg::*, psi_crc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  psr_in_if           in_ch,
  psr_out_if          out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        ext_mode;
  logic        storing;
  logic [7:0]  hdr [8];
  logic [12:0] count;
  logic [12:0] target;
  logic [31:0] crc;
  logic [31:0] err_cnt;
  logic [7:0]  pkt_pos;
  logic [7:0]  start_pos;
  logic        pass_done;
  logic        start_pending;

  out_item_t   expected_q [$];
  out_item_t   want;
  out_item_t   got;
  int unsigned fail_total;
  int unsigned results_seen;

  initial begin
    fail_total   = 0;
    results_seen = 0;
  end

  task automatic report_failure(input string msg);
    fail_total++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] g, input logic [31:0] w);
    if (g !== w) begin
      report_failure($sformatf("result %0d %s: got 0x%0h expected 0x%0h",
                               results_seen, name, g, w));
    end
  endtask

  function automatic void clear_section();
    storing = 1'b0;
    count   = '0;
    target  = '0;
    crc     = CRC_INIT;
    foreach (hdr[i]) hdr[i] = '0;
  endfunction

  function automatic logic header_valid();
    logic [11:0] len;
    len = {hdr[1][3:0], hdr[2]};
    if ((hdr[1] & FIXED_BITS_MASK) != FIXED_BITS_MASK) return 1'b0;
    if (len > MAX_SECTION_LEN) return 1'b0;
    if (hdr[1][7]) begin
      if (!ext_mode) return 1'b0;
      if ((hdr[5] & EXT_RSV_MASK) != EXT_RSV_MASK) return 1'b0;
      if (hdr[6] > hdr[7]) return 1'b0;
      if (len < MIN_EXT_LEN) return 1'b0;
    end else begin
      if (ext_mode) return 1'b0;
      if (len < MIN_STD_LEN) return 1'b0;
    end
    target = {1'b0, len} + SECTION_OVERHEAD;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t   r;
    logic        is_pointer;
    logic [12:0] hsize;
    r          = '0;
    is_pointer = 1'b0;
    if (it.packet_start) begin
      pkt_pos       = '0;
      pass_done     = 1'b0;
      start_pending = it.unit_start;
      if (it.unit_start) begin
        start_pos  = (it.payload_byte == 8'hFF) ? 8'hFF : it.payload_byte + 8'd1;
        is_pointer = 1'b1;
      end
    end else begin
      if (pkt_pos != 8'hFF) pkt_pos = pkt_pos + 8'd1;
      if (start_pending && pkt_pos == start_pos) begin
        start_pending = 1'b0;
        clear_section();
        pass_done = 1'b0;
      end
    end

    if (!is_pointer && !pass_done) begin
      hsize         = ext_mode ? HDR_EXT_BYTES : HDR_STD_BYTES;
      r.in_section  = 1'b1;
      r.byte_offset = count[11:0];
      crc           = crc32_step(crc, it.payload_byte);
      if (!storing) begin
        hdr[count[2:0]] = it.payload_byte;
        count = count + 13'd1;
        if (count >= hsize) begin
          if (header_valid()) begin
            storing = 1'b1;
          end else begin
            clear_section();
            pass_done = 1'b1;
          end
        end
      end else begin
        count = count + 13'd1;
        if (count >= target) begin
          r.section_done = 1'b1;
          r.crc_good     = (crc == 32'h0);
          if (!r.crc_good && err_cnt != 32'hFFFF_FFFF) err_cnt = err_cnt + 32'd1;
          pass_done = 1'b1;
        end
      end
    end

    r.section_byte    = it.payload_byte;
    r.crc_error_count = err_cnt;
    if (storing) begin
      r.table_id = hdr[0];
      if (ext_mode) begin
        r.table_id_extension  = {hdr[3], hdr[4]};
        r.version_number      = hdr[5][5:1];
        r.current_next        = hdr[5][0];
        r.section_number      = hdr[6];
        r.last_section_number = hdr[7];
      end
    end
    if (r.section_done) clear_section();
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ext_mode      = 1'b1;
      clear_section();
      err_cnt       = '0;
      pkt_pos       = '0;
      start_pos     = '0;
      pass_done     = 1'b0;
      start_pending = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we && cfg_wdata != ext_mode) begin
        ext_mode = cfg_wdata;
        clear_section();
        err_cnt   = '0;
        pass_done = 1'b0;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          report_failure($sformatf("result %0d transferred with nothing expected", results_seen));
        end else begin
          want = expected_q.pop_front();
          check_field("section_byte", 32'(got.section_byte), 32'(want.section_byte));
          check_field("in_section", 32'(got.in_section), 32'(want.in_section));
          check_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
          check_field("section_done", 32'(got.section_done), 32'(want.section_done));
          check_field("crc_good", 32'(got.crc_good), 32'(want.crc_good));
          check_field("crc_error_count", got.crc_error_count, want.crc_error_count);
          check_field("table_id", 32'(got.table_id), 32'(want.table_id));
          check_field("table_id_extension", 32'(got.table_id_extension),
                      32'(want.table_id_extension));
          check_field("version_number", 32'(got.version_number),
                      32'(want.version_number));
          check_field("current_next", 32'(got.current_next), 32'(want.current_next));
          check_field("section_number", 32'(got.section_number),
                      32'(want.section_number));
          check_field("last_section_number", 32'(got.last_section_number),
                      32'(want.last_section_number));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_result(in_ch.data));
      end
    end
    pending_count  <= expected_q.size();
    mismatch_count <= fail_total;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives transport-stream payload packets into the PSI section reassembler:
// a few hand-built packets, then random packet streams carrying standard and
// extended sections, with bad headers, bad crc, cut sections and raw noise.
// Both handshake sides idle at random; the checker beside the block does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psr_pkg::*;
  import psi_crc_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef enum {
    FIELDS_RANDOM,
    FIELDS_ALL_ONES,
    FIELDS_ALL_ZERO
  } field_style_e;

  typedef enum {
    HDR_FIXED_BITS,
    HDR_SYNTAX,
    HDR_RESERVED,
    HDR_NUMBERING,
    HDR_TOO_SHORT,
    HDR_TOO_LONG
  } hdr_fault_e;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 40;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CFG_SETTLE     = 4;
  localparam int TS_PAYLOAD_MAX = 184;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned mismatch_count;
  int unsigned pending_count;
  bit          no_gaps;
  bit          hold_req;
  int          items_sent;
  int          idle_cycles;
  byte_q_t     carry_q;
  byte_q_t     pkt;

  psr_in_if  ts_in ();
  psr_out_if sec_out ();

  psi_section_reassembler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ts_in     (ts_in),
    .sec_out   (sec_out)
  );

  psi_section_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (ts_in),
    .out_ch         (sec_out),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] b, input logic ps, input logic us);
    int       gap;
    in_item_t it;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    it  = '{payload_byte: b, packet_start: ps, unit_start: us};
    repeat (gap) begin
      @(negedge clk);
      ts_in.valid <= 1'b0;
    end
    @(negedge clk);
    ts_in.valid <= 1'b1;
    ts_in.data  <= it;
    do @(posedge clk); while (!(ts_in.valid && ts_in.ready));
    items_sent++;
  endtask

  // unit_start only counts on the first byte; later bytes get stray flags
  task automatic send_packet(input byte_q_t p, input logic us);
    foreach (p[i]) begin
      send_item(p[i], i == 0, (i == 0) ? us : ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    ts_in.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  task automatic write_mode(input logic v);
    settle();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void build_section(input logic ext, input int len,
                                        input field_style_e style, input bit bad_crc,
                                        input bit bad_hdr, output byte_q_t s);
    logic [7:0]  tid, ext_hi, ext_lo, sec_no, last_no;
    logic [4:0]  ver;
    logic        cur, priv;
    logic [11:0] len_field;
    logic [31:0] crc;
    int          hdr_len, pos;
    hdr_fault_e  fault;
    s         = {};
    len_field = len[11:0];
    hdr_len   = ext ? int'(HDR_EXT_BYTES) : int'(HDR_STD_BYTES);
    case (style)
      FIELDS_ALL_ONES: begin
        tid = 8'hFF; ext_hi = 8'hFF; ext_lo = 8'hFF; ver = 5'h1F; cur = 1'b1;
        sec_no = 8'hFF; last_no = 8'hFF; priv = 1'b1;
      end
      FIELDS_ALL_ZERO: begin
        tid = 8'h00; ext_hi = 8'h00; ext_lo = 8'h00; ver = 5'h00; cur = 1'b0;
        sec_no = 8'h00; last_no = 8'h00; priv = 1'b0;
      end
      default: begin
        tid     = 8'($urandom_range(0, 255));
        ext_hi  = 8'($urandom_range(0, 255));
        ext_lo  = 8'($urandom_range(0, 255));
        ver     = 5'($urandom_range(0, 31));
        cur     = 1'($urandom_range(0, 1));
        priv    = 1'($urandom_range(0, 1));
        last_no = 8'($urandom_range(0, 255));
        sec_no  = 8'($urandom_range(0, int'(last_no)));
      end
    endcase
    s.push_back(tid);
    s.push_back({ext, priv, 2'b11, len_field[11:8]});
    s.push_back(len_field[7:0]);
    if (ext) begin
      s.push_back(ext_hi);
      s.push_back(ext_lo);
      s.push_back({2'b11, ver, cur});
      s.push_back(sec_no);
      s.push_back(last_no);
    end
    while (s.size() < len + 3 - 4) s.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (s[i]) crc = crc32_step(crc, s[i]);
    s.push_back(crc[31:24]);
    s.push_back(crc[23:16]);
    s.push_back(crc[15:8]);
    s.push_back(crc[7:0]);
    if (bad_crc) begin
      pos    = $urandom_range(hdr_len, s.size() - 1);
      s[pos] = s[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (bad_hdr) begin
      fault = hdr_fault_e'($urandom_range(HDR_FIXED_BITS, HDR_TOO_LONG));
      if (!ext && (fault == HDR_RESERVED || fault == HDR_NUMBERING)) fault = HDR_SYNTAX;
      case (fault)
        HDR_FIXED_BITS: s[1] = s[1] & ~(8'h10 << $urandom_range(0, 1));
        HDR_SYNTAX:     s[1] = s[1] ^ 8'h80;
        HDR_RESERVED:   s[5] = s[5] & ~(8'h40 << $urandom_range(0, 1));
        HDR_NUMBERING: begin
          s[7] = 8'($urandom_range(0, 254));
          s[6] = 8'($urandom_range(int'(s[7]) + 1, 255));
        end
        HDR_TOO_SHORT: begin
          s[1] = {s[1][7:4], 4'h0};
          s[2] = ext ? 8'($urandom_range(0, int'(MIN_EXT_LEN) - 1))
                     : 8'($urandom_range(0, int'(MIN_STD_LEN) - 1));
        end
        default: begin
          s[1] = {s[1][7:4], 4'hF};
          s[2] = 8'hFE | 8'($urandom_range(0, 1));
        end
      endcase
    end
  endfunction

  function automatic void make_section(input logic ext, input bit longest, output byte_q_t s);
    int len;
    if (longest) begin
      len = int'(MAX_SECTION_LEN);
    end else if (ext) begin
      len = $urandom_range(int'(MIN_EXT_LEN), int'(MIN_EXT_LEN) + 20);
    end else begin
      len = $urandom_range(int'(MIN_STD_LEN), int'(MIN_STD_LEN) + 24);
    end
    build_section(ext, len, FIELDS_RANDOM, !longest && $urandom_range(0, 7) == 0,
                  !longest && $urandom_range(0, 7) == 0, s);
  endfunction

  task automatic run_random_phase(input logic ext, input int n_items, input bit with_longest);
    int      goal, len, ptr;
    bit      longest_left;
    logic    us;
    byte_q_t p, sec;
    goal         = items_sent + n_items;
    longest_left = with_longest;
    carry_q      = {};
    while (items_sent < goal || carry_q.size() != 0) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, TS_PAYLOAD_MAX)
                                            : $urandom_range(2, 24);
      if (carry_q.size() > TS_PAYLOAD_MAX) len = TS_PAYLOAD_MAX;
      p = {};
      if ($urandom_range(0, 15) == 0) begin
        // raw noise, sometimes long enough to saturate the packet position
        if ($urandom_range(0, 3) == 0) len = $urandom_range(250, 300);
        repeat (len) p.push_back(8'($urandom_range(0, 255)));
        us = 1'($urandom_range(0, 1));
        send_packet(p, us);
        if ($urandom_range(0, 1) == 0) carry_q = {};
      end else if (carry_q.size() != 0 &&
                   (items_sent >= goal || carry_q.size() + 2 > len ||
                    $urandom_range(0, 2) == 0)) begin
        repeat (len) p.push_back(carry_q.size() != 0 ? carry_q.pop_front() : 8'hFF);
        send_packet(p, 1'b0);
      end else begin
        ptr = carry_q.size();
        // cut the open section short now and then
        if (ptr != 0 && $urandom_range(0, 9) == 0) ptr = $urandom_range(0, ptr - 1);
        if (len < ptr + 2) len = ptr + 2;
        p.push_back(8'(ptr));
        repeat (ptr) p.push_back(carry_q.pop_front());
        make_section(ext, longest_left, sec);
        longest_left = 1'b0;
        while (p.size() < len) p.push_back(sec.size() != 0 ? sec.pop_front() : 8'hFF);
        carry_q = sec;
        send_packet(p, 1'b1);
      end
    end
  endtask

  // receiver: random hold-offs per transfer, one long stall on request
  initial begin
    int gap;
    sec_out.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        sec_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        sec_out.ready <= 1'b0;
      end
      @(negedge clk);
      sec_out.ready <= 1'b1;
      do @(posedge clk); while (!(sec_out.valid && sec_out.ready));
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((ts_in.valid && ts_in.ready) || (sec_out.valid && sec_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    byte_q_t sec;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    ts_in.valid <= 1'b0;
    ts_in.data  <= '0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // same value as after reset, parser keeps its state
    write_mode(1'b1);
    // bytes ahead of any packet start, with stray unit start
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    // shortest extended section, every header field at its maximum
    build_section(1'b1, int'(MIN_EXT_LEN), FIELDS_ALL_ONES, 1'b0, 1'b0, sec);
    sec.push_front(8'h00);
    send_packet(sec, 1'b1);
    // pointer past the end of the packet
    pkt = '{8'hFF, 8'h47, 8'hB0, 8'h0C};
    send_packet(pkt, 1'b1);

    write_mode(1'b0);
    // shortest standard section, every header field at zero
    build_section(1'b0, int'(MIN_STD_LEN), FIELDS_ALL_ZERO, 1'b0, 1'b0, sec);
    sec.push_front(8'h00);
    send_packet(sec, 1'b1);
    run_random_phase(1'b0, 220, 1'b0);

    write_mode(1'b1);
    hold_req = 1'b1;
    run_random_phase(1'b1, 220, 1'b0);
    settle();
    run_random_phase(1'b1, 100, 1'b0);

    write_mode(1'b0);
    run_random_phase(1'b0, 150, 1'b0);

    write_mode(1'b1);
    hold_req = 1'b1;
    run_random_phase(1'b1, 100, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
